### rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define LCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// clocked assertion that also runs during reset
`define LCD_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### rtl/lcd_pkg.sv
// shared types and constants of the leaf class distribution block
package lcd_pkg;

    localparam int CLASS_W         = 6;
    localparam int WEIGHT_W        = 16;
    localparam int NCLS_W          = 7;
    localparam int PROB_W          = 17;
    localparam int MAX_CLASSES_DEF = 64;
    localparam int ACC_WIDTH_DEF   = 40;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 7;
    localparam int DIV_STEPS       = 17;

    localparam logic [WEIGHT_W-1:0] ONE_Q8_8   = 16'd256;
    localparam logic [PROB_W-1:0]   PROB_ONE   = 17'd65536;
    localparam logic [NCLS_W-1:0]   NCLS_RESET = 7'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_CLASSES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_WEIGHTS = 1'b1;

    typedef struct packed {
        logic [CLASS_W-1:0]  class_label;
        logic [WEIGHT_W-1:0] sample_weight;
        logic                last_sample;
    } lcd_in_t;

    typedef struct packed {
        logic [CLASS_W-1:0] class_index;
        logic [PROB_W-1:0]  probability;
        logic               zero_total;
        logic               last_result;
    } lcd_out_t;

    typedef struct packed {
        logic [CLASS_W-1:0]  idx;
        logic                in_range;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } lcd_qent_t;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_EM_RD,
        ST_EM_LD,
        ST_EM_DIV,
        ST_EM_PUT,
        ST_EM_ERR
    } lcd_state_t;

endpackage

### rtl/lcd_ram.sv
// generic single-write, single-read ram with registered read
module lcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lcd_front.sv
// request intake: label range check and weight selection
module lcd_front import lcd_pkg::*; #(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
    input  logic              s_valid,
    output logic              s_ready,
    input  lcd_in_t           s_data,
    input  logic [NCLS_W-1:0] n_eff,
    input  logic              use_weights,
    output logic              q_push,
    output lcd_qent_t         q_entry,
    input  logic              q_full
);

    logic below_n;
    logic below_max;

    always_comb begin
        below_n   = {1'b0, s_data.class_label} < n_eff;
        below_max = 32'(s_data.class_label) < MAX_CLASSES;

        q_entry.idx      = s_data.class_label;
        q_entry.in_range = below_n && below_max;
        q_entry.weight   = use_weights ? s_data.sample_weight : ONE_Q8_8;
        q_entry.last     = s_data.last_sample;

        s_ready = !q_full;
        q_push  = s_valid && !q_full;
    end

endmodule

### rtl/lcd_queue.sv
// short request queue between intake and accumulator
module lcd_queue import lcd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  lcd_qent_t push_data,
    output logic      full,
    input  logic      pop,
    output lcd_qent_t pop_data,
    output logic      empty
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    lcd_qent_t       mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    always_comb begin
        full  = cnt_reg == CW'(QUEUE_DEPTH);
        empty = cnt_reg == '0;
        pop_data = mem_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/lcd_div.sv
// radix-2 restoring divider giving a rounded q1.16 ratio
module lcd_div import lcd_pkg::*; #(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [ACC_WIDTH-1:0] num,
    input  logic [ACC_WIDTH-1:0] den,
    output logic                 done,
    output logic [PROB_W-1:0]    quot
);

    localparam int CNTW = $clog2(DIV_STEPS + 1);

    logic [ACC_WIDTH-1:0] r_reg, r_next;
    logic [ACC_WIDTH-1:0] den_reg, den_next;
    logic [DIV_STEPS:0]   q_reg, q_next;
    logic [CNTW-1:0]      cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [ACC_WIDTH:0]   r_shift;
    logic [ACC_WIDTH:0]   r_diff;
    logic [DIV_STEPS:0]   rnd;

    always_comb begin
        r_next    = r_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        r_shift   = {r_reg, 1'b0};
        r_diff    = r_shift - {1'b0, den_reg};

        if (start) begin
            den_next  = den;
            cnt_next  = CNTW'(DIV_STEPS);
            busy_next = 1'b1;
            done_next = 1'b0;
            if (num >= den) begin
                r_next = num - den;
                q_next = (DIV_STEPS + 1)'(1);
            end else begin
                r_next = num;
                q_next = '0;
            end
        end else if (busy_reg) begin
            if (r_shift >= {1'b0, den_reg}) begin
                r_next = r_diff[ACC_WIDTH-1:0];
                q_next = {q_reg[DIV_STEPS-1:0], 1'b1};
            end else begin
                r_next = r_shift[ACC_WIDTH-1:0];
                q_next = {q_reg[DIV_STEPS-1:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end

        // extra fraction bit rounds ties up
        rnd  = {1'b0, q_reg[DIV_STEPS:1]} + (DIV_STEPS + 1)'(q_reg[0]);
        quot = (rnd > (DIV_STEPS + 1)'(PROB_ONE)) ? PROB_ONE : rnd[PROB_W-1:0];
        done = done_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        r_reg   <= r_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

endmodule

### rtl/lcd_back.sv
// bin accumulator and per-class emission sequencer
module lcd_back import lcd_pkg::*; #(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int ACC_WIDTH   = ACC_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    output logic              q_pop,
    input  lcd_qent_t         q_entry,
    input  logic [NCLS_W-1:0] n_eff,
    output logic              m_valid,
    input  logic              m_ready,
    output lcd_out_t          m_data
);

    localparam int AW = $clog2(MAX_CLASSES);

    lcd_state_t           state_reg, state_next;
    logic                 s2_vld_reg;
    lcd_qent_t            s2_ent_reg;
    logic                 fwd_vld_reg, fwd_vld_next;
    logic [AW-1:0]        fwd_addr_reg;
    logic [ACC_WIDTH-1:0] fwd_data_reg;
    logic [ACC_WIDTH-1:0] total_reg, total_next;
    logic [MAX_CLASSES-1:0] bin_vld_reg, bin_vld_next;
    logic [NCLS_W-1:0]    k_reg, k_next;
    logic                 out_vld_reg, out_vld_next;
    lcd_out_t             out_reg, out_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [ACC_WIDTH-1:0] ram_rdata;
    logic [AW-1:0]        s2_addr;
    logic [AW-1:0]        k_addr;
    logic [ACC_WIDTH-1:0] w_ext;
    logic [ACC_WIDTH-1:0] bin_old;
    logic [ACC_WIDTH-1:0] bin_new;
    logic [ACC_WIDTH:0]   bin_sum;
    logic [ACC_WIDTH:0]   total_sum;
    logic [ACC_WIDTH-1:0] bin_k;
    logic [ACC_WIDTH-1:0] div_num;
    logic                 div_start;
    logic                 div_done;
    logic [PROB_W-1:0]    div_quot;
    logic                 out_free;
    logic                 clr;

    lcd_ram #(
        .WIDTH (ACC_WIDTH),
        .DEPTH (MAX_CLASSES)
    ) u_bins (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s2_addr),
        .wdata (bin_new),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lcd_div #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (total_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        s2_addr = AW'(s2_ent_reg.idx);
        k_addr  = AW'(k_reg);
        w_ext   = ACC_WIDTH'(s2_ent_reg.weight);

        // one-deep forward covers the read issued alongside the previous write
        if (fwd_vld_reg && fwd_addr_reg == s2_addr) begin
            bin_old = fwd_data_reg;
        end else if (bin_vld_reg[s2_addr]) begin
            bin_old = ram_rdata;
        end else begin
            bin_old = '0;
        end
        bin_sum   = {1'b0, bin_old} + {1'b0, w_ext};
        bin_new   = bin_sum[ACC_WIDTH] ? '1 : bin_sum[ACC_WIDTH-1:0];
        total_sum = {1'b0, total_reg} + {1'b0, w_ext};

        bin_k   = bin_vld_reg[k_addr] ? ram_rdata : '0;
        div_num = (bin_k > total_reg) ? total_reg : bin_k;

        out_free = !out_vld_reg || m_ready;
        ram_we   = s2_vld_reg && s2_ent_reg.in_range;

        state_next   = state_reg;
        q_pop        = 1'b0;
        ram_raddr    = AW'(q_entry.idx);
        k_next       = k_reg;
        div_start    = 1'b0;
        clr          = 1'b0;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && !m_ready;

        unique case (state_reg)
            ST_ACC: begin
                q_pop = !q_empty && !(s2_vld_reg && s2_ent_reg.last);
                if (s2_vld_reg && s2_ent_reg.last) begin
                    k_next     = '0;
                    state_next = ST_EM_RD;
                end
            end
            ST_EM_RD: begin
                ram_raddr  = k_addr;
                state_next = (total_reg == '0) ? ST_EM_ERR : ST_EM_LD;
            end
            ST_EM_LD: begin
                div_start  = 1'b1;
                state_next = ST_EM_DIV;
            end
            ST_EM_DIV: begin
                if (div_done) begin
                    state_next = ST_EM_PUT;
                end
            end
            ST_EM_PUT: begin
                if (out_free) begin
                    out_vld_next         = 1'b1;
                    out_next.class_index = CLASS_W'(k_reg);
                    out_next.probability = div_quot;
                    out_next.zero_total  = 1'b0;
                    out_next.last_result = k_reg == n_eff - 1'b1;
                    if (k_reg == n_eff - 1'b1) begin
                        clr        = 1'b1;
                        state_next = ST_ACC;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_EM_RD;
                    end
                end
            end
            ST_EM_ERR: begin
                if (out_free) begin
                    out_vld_next         = 1'b1;
                    out_next.class_index = '0;
                    out_next.probability = '0;
                    out_next.zero_total  = 1'b1;
                    out_next.last_result = 1'b1;
                    clr                  = 1'b1;
                    state_next           = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase

        total_next   = total_reg;
        bin_vld_next = bin_vld_reg;
        fwd_vld_next = fwd_vld_reg;
        if (ram_we) begin
            total_next            = total_sum[ACC_WIDTH] ? '1 : total_sum[ACC_WIDTH-1:0];
            bin_vld_next[s2_addr] = 1'b1;
            fwd_vld_next          = 1'b1;
        end
        if (clr) begin
            total_next   = '0;
            bin_vld_next = '0;
            fwd_vld_next = 1'b0;
        end

        m_valid = out_vld_reg;
        m_data  = out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACC;
            s2_vld_reg  <= 1'b0;
            fwd_vld_reg <= 1'b0;
            total_reg   <= '0;
            bin_vld_reg <= '0;
            k_reg       <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s2_vld_reg  <= q_pop;
            fwd_vld_reg <= fwd_vld_next;
            total_reg   <= total_next;
            bin_vld_reg <= bin_vld_next;
            k_reg       <= k_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s2_ent_reg <= q_entry;
        end
        if (ram_we) begin
            fwd_addr_reg <= s2_addr;
            fwd_data_reg <= bin_new;
        end
        out_reg <= out_next;
    end

endmodule

### rtl/leaf_class_distribution_core.sv
// top level of the leaf class distribution block
// s_ channel: one request per sample (class label, q8.8 weight, last mark),
// valid/ready; up to one request per cycle while a leaf accumulates.
// m_ channel: one result per class 0..n-1 after the last sample, or one
// error result with zero_total set when the leaf weight is zero.
// cfg port: cfg_we/cfg_idx/cfg_wdata set num_classes and use_weights;
// write only while the block is idle.
// intake: an accepted request reaches its bin through a 2-entry queue and a
// read-modify-write pipeline on the bin ram.
// emission: each class takes a bin read, the 17-step serial divider and the
// result hand-off; an error result skips the divider.
// intake keeps filling the queue during emission and stalls once it is full.
// reset clears the bins (valid flags), total and output valid flag at once;
// num_classes returns to 2 and use_weights to 0.
// a stalled m_ channel holds its result and pauses emission.
module leaf_class_distribution_core import lcd_pkg::*; #(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int ACC_WIDTH   = ACC_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lcd_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lcd_out_t              m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [NCLS_W-1:0] ncls_reg, ncls_next;
    logic              use_w_reg, use_w_next;
    logic [NCLS_W-1:0] n_eff;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    lcd_qent_t         q_in;
    lcd_qent_t         q_out;

    always_comb begin
        ncls_next  = ncls_reg;
        use_w_next = use_w_reg;
        if (cfg_we) begin
            unique case (cfg_idx)
                REG_NUM_CLASSES: ncls_next  = cfg_wdata[NCLS_W-1:0];
                REG_USE_WEIGHTS: use_w_next = cfg_wdata[0];
                default: ;
            endcase
        end

        if (ncls_reg == '0) begin
            n_eff = NCLS_W'(1);
        end else if (32'(ncls_reg) > MAX_CLASSES) begin
            n_eff = NCLS_W'(MAX_CLASSES);
        end else begin
            n_eff = ncls_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ncls_reg  <= NCLS_RESET;
            use_w_reg <= 1'b0;
        end else begin
            ncls_reg  <= ncls_next;
            use_w_reg <= use_w_next;
        end
    end

    lcd_front #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .n_eff       (n_eff),
        .use_weights (use_w_reg),
        .q_push      (q_push),
        .q_entry     (q_in),
        .q_full      (q_full)
    );

    lcd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    lcd_back #(
        .MAX_CLASSES (MAX_CLASSES),
        .ACC_WIDTH   (ACC_WIDTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_entry (q_out),
        .n_eff   (n_eff),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### rtl/lcd_checker.sv
// port-level checks on the result channel, bound to the top level
`include "assert_macros.svh"

module lcd_checker import lcd_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     m_valid,
    input logic     m_ready,
    input lcd_out_t m_data
);

    `LCD_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")
    `LCD_ASSERT(a_err_form, m_valid && m_data.zero_total |-> m_data.last_result && m_data.class_index == '0 && m_data.probability == '0, "malformed error result")
    `LCD_ASSERT(a_prob_max, m_valid |-> m_data.probability <= PROB_ONE, "probability above one")
    `LCD_ASSERT_RST(a_rst_idle, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind leaf_class_distribution_core lcd_checker u_lcd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
